@@ hdl/prc_pkg.sv @@
// shared constants, types and state encodings of the prime range counter
package prc_pkg;

	localparam int VALUE_BITS = 20;
	localparam int FIELD_W    = 20;
	localparam int ID_W       = 16;
	localparam int COUNT_W    = 21;
	localparam int SQ_W       = VALUE_BITS + 1;
	localparam int STEP_W     = $clog2(VALUE_BITS);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [FIELD_W-1:0]    field_t;
	typedef logic [SQ_W-1:0]       sq_t;
	typedef logic [COUNT_W-1:0]    count_t;
	typedef logic [ID_W-1:0]       id_t;
	typedef logic [STEP_W-1:0]     step_t;

	localparam step_t  STEP_LAST = STEP_W'(VALUE_BITS - 1);
	localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic {
		REM_IDLE,
		REM_RUN
	} rem_state_t;

	typedef enum logic [1:0] {
		TR_IDLE,
		TR_CHECK,
		TR_WAIT
	} trial_state_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TEST,
		ST_WAIT,
		ST_FINISH
	} top_state_t;

	typedef struct packed {
		logic   start;
		value_t dividend;
		value_t divisor;
	} rem_req_t;

	typedef struct packed {
		logic done;
		logic zero;
	} rem_rsp_t;

	typedef struct packed {
		logic   start;
		value_t value;
	} trial_req_t;

	typedef struct packed {
		logic done;
		logic prime;
	} trial_rsp_t;

	// fit an input field to the value width: zero extend or drop high bits
	function automatic value_t fit_value(input field_t x);
		logic [FIELD_W+VALUE_BITS-1:0] wide;
		wide = {{VALUE_BITS{1'b0}}, x};
		return wide[VALUE_BITS-1:0];
	endfunction

endpackage

@@ hdl/prc_rem_unit.sv @@
// bit-serial restoring remainder unit, one dividend bit per cycle
module prc_rem_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  prc_pkg::rem_req_t req,
	output prc_pkg::rem_rsp_t rsp
);
	import prc_pkg::*;

	rem_state_t state_q, state_d;
	step_t      step_q, step_d;
	value_t     shift_q, shift_d;
	value_t     div_q, div_d;
	value_t     rem_q, rem_d;
	logic       done_q, done_d;
	logic       zero_q, zero_d;

	logic [VALUE_BITS:0] trial;
	logic [VALUE_BITS:0] diff;
	value_t              rem_next;

	// one restoring step: bring in the next dividend bit, subtract if it fits
	always_comb begin
		trial    = {rem_q, shift_q[VALUE_BITS-1]};
		diff     = trial - {1'b0, div_q};
		rem_next = (trial >= {1'b0, div_q}) ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
	end

	// next state and datapath updates
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		shift_d = shift_q;
		div_d   = div_q;
		rem_d   = rem_q;
		done_d  = 1'b0;
		zero_d  = zero_q;
		unique case (state_q)
			REM_IDLE: begin
				if (req.start) begin
					shift_d = req.dividend;
					div_d   = req.divisor;
					rem_d   = '0;
					step_d  = '0;
					state_d = REM_RUN;
				end
			end
			REM_RUN: begin
				rem_d   = rem_next;
				shift_d = {shift_q[VALUE_BITS-2:0], 1'b0};
				step_d  = step_q + step_t'(1);
				if (step_q == STEP_LAST) begin
					done_d  = 1'b1;
					zero_d  = (rem_next == '0);
					state_d = REM_IDLE;
				end
			end
			default: state_d = REM_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= REM_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			done_q  <= done_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		shift_q <= shift_d;
		div_q   <= div_d;
		rem_q   <= rem_d;
		zero_q  <= zero_d;
	end

	assign rsp.done = done_q;
	assign rsp.zero = zero_q;

endmodule

@@ hdl/prc_trial.sv @@
// primality test of one value by trial division over 2 and the odd divisors
module prc_trial (
	input  logic                clk,
	input  logic                arst_n,
	input  prc_pkg::trial_req_t req,
	output prc_pkg::trial_rsp_t rsp
);
	import prc_pkg::*;

	trial_state_t state_q, state_d;
	value_t       n_q, n_d;
	value_t       d_q, d_d;
	sq_t          sq_q, sq_d;
	logic         done_q, done_d;
	logic         prime_q, prime_d;

	rem_req_t rem_req;
	rem_rsp_t rem_rsp;

	logic sq_over;

	prc_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// divisor squared already past the value: no divisor left to try
	assign sq_over = (sq_q > {1'b0, n_q});

	// divisor walk: 2, 3, 5, 7, ... with the square kept alongside
	always_comb begin
		state_d  = state_q;
		n_d      = n_q;
		d_d      = d_q;
		sq_d     = sq_q;
		done_d   = 1'b0;
		prime_d  = prime_q;
		rem_req.start    = 1'b0;
		rem_req.dividend = n_q;
		rem_req.divisor  = d_q;
		unique case (state_q)
			TR_IDLE: begin
				if (req.start) begin
					n_d  = req.value;
					d_d  = value_t'(2);
					sq_d = sq_t'(4);
					if (req.value < value_t'(2)) begin
						done_d  = 1'b1;
						prime_d = 1'b0;
					end else begin
						state_d = TR_CHECK;
					end
				end
			end
			TR_CHECK: begin
				if (sq_over) begin
					done_d  = 1'b1;
					prime_d = 1'b1;
					state_d = TR_IDLE;
				end else begin
					rem_req.start = 1'b1;
					state_d       = TR_WAIT;
				end
			end
			TR_WAIT: begin
				if (rem_rsp.done) begin
					if (rem_rsp.zero) begin
						done_d  = 1'b1;
						prime_d = 1'b0;
						state_d = TR_IDLE;
					end else begin
						state_d = TR_CHECK;
						if (d_q == value_t'(2)) begin
							d_d  = value_t'(3);
							sq_d = sq_t'(9);
						end else begin
							// (d+2)^2 = d^2 + 4d + 4
							d_d  = d_q + value_t'(2);
							sq_d = sq_q + ({1'b0, d_q} << 2) + sq_t'(4);
						end
					end
				end
			end
			default: state_d = TR_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TR_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		n_q     <= n_d;
		d_q     <= d_d;
		sq_q    <= sq_d;
		prime_q <= prime_d;
	end

	assign rsp.done  = done_q;
	assign rsp.prime = prime_q;

endmodule

@@ hdl/prime_range_counter_top.sv @@
// top level of the prime range counter: task intake, range walk, result register
//
// Each task carries a tag and an inclusive range; the block returns the tag
// with the number of primes in that range (zero when low is above high; zero
// and one never count). Candidates are tested one after another by trial
// division with 2 and then the odd divisors up to the square root. Every trial
// division is a check of the divisor square, VALUE_BITS bit-serial remainder
// steps and the registered remainder flag. A prime candidate runs through
// every divisor up to its square root, a composite stops at its smallest
// factor, and zero and one are rejected without any division. A task costs
// the sum over its range plus intake and hand-off. One task is in work at a
// time; a new task is taken as soon as the previous count is in the output
// register, even while that result still waits to be transferred.
module prime_range_counter_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  prc_pkg::id_t     task_id,
	input  prc_pkg::field_t  range_low,
	input  prc_pkg::field_t  range_high,
	output logic             out_valid,
	input  logic             out_ready,
	output prc_pkg::id_t     done_id,
	output prc_pkg::count_t  prime_count
);
	import prc_pkg::*;

	top_state_t state_q, state_d;
	id_t        id_q, id_d;
	value_t     n_q, n_d;
	value_t     hi_q, hi_d;
	count_t     count_q, count_d;
	logic       out_valid_q;
	id_t        done_id_q;
	count_t     prime_count_q;
	logic       out_load;

	trial_req_t trial_req;
	trial_rsp_t trial_rsp;

	value_t lo_in;
	value_t hi_in;

	prc_trial u_trial (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (trial_req),
		.rsp    (trial_rsp)
	);

	assign lo_in = fit_value(range_low);
	assign hi_in = fit_value(range_high);

	// range walk over the candidates of one task
	always_comb begin
		state_d  = state_q;
		id_d     = id_q;
		n_d      = n_q;
		hi_d     = hi_q;
		count_d  = count_q;
		out_load = 1'b0;
		in_ready = 1'b0;
		trial_req.start = 1'b0;
		trial_req.value = n_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					id_d    = task_id;
					n_d     = lo_in;
					hi_d    = hi_in;
					count_d = '0;
					state_d = (lo_in > hi_in) ? ST_FINISH : ST_TEST;
				end
			end
			ST_TEST: begin
				trial_req.start = 1'b1;
				state_d         = ST_WAIT;
			end
			ST_WAIT: begin
				if (trial_rsp.done) begin
					if (trial_rsp.prime && (count_q != COUNT_MAX)) begin
						count_d = count_q + count_t'(1);
					end
					if (n_q == hi_q) begin
						state_d = ST_FINISH;
					end else begin
						n_d     = n_q + value_t'(1);
						state_d = ST_TEST;
					end
				end
			end
			ST_FINISH: begin
				// hand the count over once the result register is free
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// task and result registers
	always_ff @(posedge clk) begin
		id_q    <= id_d;
		n_q     <= n_d;
		hi_q    <= hi_d;
		count_q <= count_d;
		if (out_load) begin
			done_id_q     <= id_q;
			prime_count_q <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign done_id     = done_id_q;
	assign prime_count = prime_count_q;

endmodule

@@ bench/prime_range_counter_top_test.sv @@
// self-checking testbench of the prime range counter top level
`timescale 1ns / 1ps

module prime_range_counter_top_test;
	import prc_pkg::*;

	// one expected transfer on the result channel
	typedef struct {
		id_t    id;
		count_t count;
	} tally_t;

	// expected counts in arrival order, checked against every result transfer
	class prime_count_board;
		tally_t      awaited[$];
		int unsigned errors;

		function new();
			errors = 0;
		endfunction

		// trial division, zero and one never count
		function bit is_prime(longint unsigned n);
			longint unsigned d;
			if (n < 2) begin
				return 1'b0;
			end
			for (d = 2; d * d <= n; d++) begin
				if (n % d == 0) begin
					return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		// primes in the inclusive range after fitting both ends to the value width
		function count_t primes_in_range(field_t lo, field_t hi);
			longint unsigned mask;
			longint unsigned first;
			longint unsigned last;
			longint unsigned n;
			longint unsigned total;
			mask  = (64'd1 << VALUE_BITS) - 1;
			first = longint'(lo) & mask;
			last  = longint'(hi) & mask;
			total = 0;
			if (first <= last) begin
				for (n = first; n <= last; n++) begin
					if (is_prime(n)) begin
						total++;
					end
				end
			end
			if (total > longint'(COUNT_MAX)) begin
				total = longint'(COUNT_MAX);
			end
			return count_t'(total);
		endfunction

		function void note_task(id_t id, field_t lo, field_t hi);
			tally_t t;
			t.id    = id;
			t.count = primes_in_range(lo, hi);
			awaited.push_back(t);
		endfunction

		function void check_result(id_t id, count_t count);
			tally_t t;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result: done_id %0d prime_count %0d",
					$time, id, count);
				errors++;
				return;
			end
			t = awaited.pop_front();
			if (id !== t.id) begin
				$display("%0t: done_id mismatch: expected %0d, actual %0d", $time, t.id, id);
				errors++;
			end
			if (count !== t.count) begin
				$display("%0t: prime_count mismatch: expected %0d, actual %0d",
					$time, t.count, count);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction
	endclass

	localparam int     DIRECTED_N = 20;
	localparam int     RANDOM_N   = 80;
	localparam int     GAP_MAX    = 13;
	localparam int     HOLD_LONG  = 50000;
	localparam field_t VALUE_TOP  = '1;

	// directed ranges: zero and one, the smallest primes, empty ranges, field extremes
	localparam field_t DIR_LOW[DIRECTED_N] = '{
		20'd0, 20'd1, 20'd0, 20'd2, 20'd0, 20'd3, 20'd4, 20'd0, 20'd5, 20'd11,
		20'hFFFFF, 20'hFFFFF, 20'hFFFFE, 20'd1048573, 20'd1048550, 20'd997,
		20'd65519, 20'd4093, 20'd1000000, 20'h80000
	};
	localparam field_t DIR_HIGH[DIRECTED_N] = '{
		20'd0, 20'd1, 20'd1, 20'd2, 20'd2, 20'd3, 20'd4, 20'd100, 20'd3, 20'd10,
		20'hFFFFF, 20'd0, 20'hFFFFF, 20'd1048573, 20'd1048575, 20'd1009,
		20'd65537, 20'd4099, 20'd1000036, 20'h7FFFF
	};

	logic   clk         = 1'b0;
	logic   arst_n      = 1'b0;
	logic   in_valid    = 1'b0;
	logic   in_ready;
	id_t    task_id     = '0;
	field_t range_low   = '0;
	field_t range_high  = '0;
	logic   out_valid;
	logic   out_ready   = 1'b0;
	id_t    done_id;
	count_t prime_count;

	prime_count_board board = new();
	int unsigned      sent_count  = 0;
	int unsigned      seen_count  = 0;
	longint unsigned  cycle_count = 0;
	longint unsigned  cycle_limit = 100000;

	prime_range_counter_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.task_id     (task_id),
		.range_low   (range_low),
		.range_high  (range_high),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.done_id     (done_id),
		.prime_count (prime_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// upper bound on the walk: every candidate pays the full divisor search
	function automatic longint unsigned walk_cycles(field_t lo, field_t hi);
		longint unsigned total;
		longint unsigned n;
		longint unsigned r;
		total = 64 + 2 * GAP_MAX;
		if (lo <= hi) begin
			for (n = lo; n <= hi; n++) begin
				r = 1;
				while (r * r <= n) begin
					r++;
				end
				total += (VALUE_BITS + 2) * (r / 2 + 2) + 4;
			end
		end
		return total;
	endfunction

	// one input transfer; called and left at a falling edge
	task automatic offer_task(id_t id, field_t lo, field_t hi);
		int unsigned gap;
		gap = ((sent_count / 12) % 3 != 1) ? $urandom_range(0, GAP_MAX) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		task_id    <= id;
		range_low  <= lo;
		range_high <= hi;
		do @(posedge clk); while (!in_ready);
		board.note_task(id, lo, hi);
		cycle_limit += 4 * walk_cycles(lo, hi);
		sent_count++;
		@(negedge clk);
	endtask

	// random range: mostly short walks over small values, a few of one or two values anywhere, some empty
	task automatic offer_random();
		field_t lo;
		field_t hi;
		field_t w;
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				w  = $urandom_range(0, 1);
				lo = $urandom_range(0, VALUE_TOP);
				if (lo > VALUE_TOP - w) begin
					lo = VALUE_TOP - w;
				end
				hi = lo + w;
			end
			3, 4: begin
				lo = $urandom_range(1, VALUE_TOP);
				hi = $urandom_range(0, lo - 1);
			end
			default: begin
				lo = $urandom_range(0, 1000);
				hi = lo + $urandom_range(0, 24);
			end
		endcase
		offer_task(id_t'($urandom_range(0, 16'hFFFF)), lo, hi);
	endtask

	// stimulus and end of run
	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int i = 0; i < DIRECTED_N; i++) begin
			offer_task((i % 2 == 0) ? id_t'(16'hFFFF - i) : id_t'(i), DIR_LOW[i], DIR_HIGH[i]);
		end
		for (int i = 0; i < RANDOM_N; i++) begin
			// pause the sender until every count is back
			if (i == 60) begin
				in_valid <= 1'b0;
				@(negedge clk);
				while (board.pending() != 0) @(negedge clk);
			end
			offer_random();
		end
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// result side: random hold-off on most transfers, one long stall to back up the input
	initial begin
		int unsigned gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (seen_count == 30) begin
				gap = HOLD_LONG;
			end else if ((seen_count / 10) % 3 != 2) begin
				gap = $urandom_range(0, GAP_MAX);
			end else begin
				gap = 0;
			end
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			board.check_result(done_id, prime_count);
			seen_count++;
			@(negedge clk);
		end
	end

	// watchdog, the limit grows with the work of every accepted task
	initial begin
		while (cycle_count <= cycle_limit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
